@@ rtl/core/analog_keypad_code_lock_assert.svh @@
// ----------------------------------------------------------------------------
// Keypad code lock assertion macros
// Shared concurrent-check wrappers; clocked on the rising edge, muted in reset.
// ----------------------------------------------------------------------------
`ifndef ANALOG_KEYPAD_CODE_LOCK_ASSERT_SVH
`define ANALOG_KEYPAD_CODE_LOCK_ASSERT_SVH

// Same-cycle implication.
`define ALK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ALK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/alk_pkg.sv @@
// ----------------------------------------------------------------------------
// Keypad code lock package
// Shared types, ladder tables and register codes.
// ----------------------------------------------------------------------------
package alk_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int KEY_W     = 4;
  localparam int REG_W     = 16;
  localparam int CNT_W     = 3;
  localparam int KEY_BANDS = 16;

  // Press tracking phase; confirm is transient and behaves as idle.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_SETTLE  = 2'd1,
    PH_CONFIRM = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  // Configuration register indexes
  localparam logic REG_CODE_DIGITS    = 1'b0;
  localparam logic REG_SETTLE_SAMPLES = 1'b1;

  localparam logic [REG_W-1:0] CODE_RESET   = 16'h1597;
  localparam logic [REG_W-1:0] SETTLE_RESET = 16'd50;

  // Ladder thresholds; band i lies strictly between edge i and edge i+1.
  localparam logic [SAMPLE_W:0] BAND_EDGE [0:KEY_BANDS] = '{
    11'd118, 11'd170, 11'd220, 11'd272, 11'd320, 11'd370, 11'd422, 11'd475,
    11'd526, 11'd578, 11'd629, 11'd686, 11'd741, 11'd801, 11'd862, 11'd897,
    11'd1024
  };

  // Key value per band
  localparam logic [KEY_W-1:0] BAND_KEY [0:KEY_BANDS-1] = '{
    4'd1, 4'd4, 4'd7, 4'd10, 4'd2, 4'd5, 4'd8, 4'd0,
    4'd3, 4'd6, 4'd9, 4'd11, 4'd15, 4'd14, 4'd13, 4'd12
  };

  localparam logic [KEY_W-1:0] MAX_DIGIT = 4'd9;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] band;
  } band_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] code;
  } key_evt_t;

  typedef struct packed {
    logic             done;
    logic             correct;
    logic [CNT_W-1:0] count;
  } entry_t;

endpackage

@@ rtl/core/alk_band.sv @@
// ----------------------------------------------------------------------------
// Keypad code lock band decoder
// Parallel strict-window compares of one sample against the ladder edges.
// ----------------------------------------------------------------------------
module alk_band (
  input  logic [alk_pkg::SAMPLE_W-1:0] sample,
  output alk_pkg::band_t               band
);
  import alk_pkg::*;

  logic [SAMPLE_W:0] s_ext;

  assign s_ext = {1'b0, sample};

  // Windows are disjoint, so at most one compare hits.
  always_comb begin
    band = '0;
    for (int i = KEY_BANDS - 1; i >= 0; i--) begin
      if (s_ext > BAND_EDGE[i] && s_ext < BAND_EDGE[i+1]) begin
        band.hit  = 1'b1;
        band.band = KEY_W'(i);
      end
    end
  end

endmodule

@@ rtl/core/alk_press.sv @@
// ----------------------------------------------------------------------------
// Keypad code lock press tracker
// Settle, confirm and release sequencing; reports a key on release.
// ----------------------------------------------------------------------------
module alk_press (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic [alk_pkg::SAMPLE_W-1:0]  sample,
  input  alk_pkg::band_t                band,
  input  logic [alk_pkg::REG_W-1:0]     settle_samples,
  output alk_pkg::key_evt_t             key_evt
);
  import alk_pkg::*;

  localparam logic [SAMPLE_W-1:0] RELEASE_LEVEL = BAND_EDGE[0][SAMPLE_W-1:0];

  phase_t           phase_r, phase_nxt;
  logic [KEY_W-1:0] first_band_r, first_band_nxt;
  logic [REG_W-1:0] settle_count_r, settle_count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      first_band_r   <= '0;
      settle_count_r <= '0;
    end else if (advance) begin
      phase_r        <= phase_nxt;
      first_band_r   <= first_band_nxt;
      settle_count_r <= settle_count_nxt;
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    first_band_nxt   = first_band_r;
    settle_count_nxt = settle_count_r;
    key_evt.valid    = 1'b0;
    key_evt.code     = BAND_KEY[first_band_r];
    unique case (phase_r)
      PH_SETTLE: begin
        if (settle_count_r >= settle_samples) begin
          // this sample confirms or drops the press
          if (band.hit && band.band == first_band_r) begin
            phase_nxt = PH_RELEASE;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end else begin
          settle_count_nxt = settle_count_r + 1'b1;
        end
      end
      PH_RELEASE: begin
        if (sample <= RELEASE_LEVEL) begin
          phase_nxt     = PH_IDLE;
          key_evt.valid = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (band.hit) begin
          first_band_nxt   = band.band;
          settle_count_nxt = '0;
          phase_nxt        = PH_SETTLE;
        end
      end
    endcase
  end

endmodule

@@ rtl/core/alk_entry.sv @@
// ----------------------------------------------------------------------------
// Keypad code lock entry collector
// Stores digit keys and compares a full entry with the configured code.
// ----------------------------------------------------------------------------
module alk_entry #(
  parameter int CODE_LENGTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  alk_pkg::key_evt_t          key_evt,
  input  logic [alk_pkg::REG_W-1:0]  code_digits,
  output alk_pkg::entry_t            entry
);
  import alk_pkg::*;

  localparam int POS_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [CNT_W:0] LEN = (CNT_W + 1)'(CODE_LENGTH);

  logic [CNT_W-1:0]   digit_count_r, digit_count_nxt;
  logic [KEY_W-1:0]   digits_r [CODE_LENGTH];
  logic               is_digit;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W:0]     pos_inc;
  logic               done;
  logic [KEY_W-1:0]   want  [CODE_LENGTH];
  logic [CODE_LENGTH-1:0] match;

  assign is_digit = key_evt.valid && (key_evt.code <= MAX_DIGIT);
  assign pos      = ({1'b0, digit_count_r} >= LEN) ? '0 : digit_count_r;
  assign pos_inc  = {1'b0, pos} + 1'b1;
  assign done     = is_digit && (pos_inc >= LEN);

  // Expected digit per position; nibbles past the register read as zero.
  for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_cmp
    localparam int Sh = 4 * (CODE_LENGTH - 1 - i);
    if (Sh < REG_W) begin : g_in
      assign want[i] = code_digits[Sh +: KEY_W];
    end else begin : g_out
      assign want[i] = '0;
    end
    // the digit being written now takes part in the compare
    assign match[i] = ((pos == CNT_W'(i)) ? key_evt.code : digits_r[i]) == want[i];
  end

  always_comb begin
    digit_count_nxt = digit_count_r;
    if (is_digit) begin
      digit_count_nxt = done ? '0 : pos_inc[CNT_W-1:0];
    end
  end

  assign entry.done    = done;
  assign entry.correct = done && (&match);
  assign entry.count   = digit_count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= '0;
    end else if (advance) begin
      digit_count_r <= digit_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_digit) begin
      digits_r[pos[POS_W-1:0]] <= key_evt.code;
    end
  end

endmodule

@@ rtl/core/analog_keypad_code_lock.sv @@
// ----------------------------------------------------------------------------
// Analog keypad code lock
// Resistor-ladder keypad decoder with debounce and four-digit code check.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                  | Moves
//  --------+----------------------------------------+---------------------------
//  in      | in_valid, in_stall, in_adc_sample      | one ADC sample per request
//  out     | out_valid, out_stall, out_key_* ...    | one result per request
//  cfg     | cfg_we, cfg_index, cfg_wdata           | register write, no wait
//
//  One request per cycle sustained while out_stall is low: the sample lands
//  in the input register, band decode plus the press and entry update are
//  combinational, and the result register takes it and raises out_valid.
//  Synchronous active-low reset clears phase, counters and both valid flags;
//  config registers return to code 0x1597 and settle count 50.
//  A stalled result holds; the input register still takes a request while
//  the result waits, and in_stall rises only when both registers are full
//  and out_stall is high.
// ----------------------------------------------------------------------------
module analog_keypad_code_lock #(
  parameter int CODE_LENGTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample request
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [alk_pkg::SAMPLE_W-1:0]  in_adc_sample,
  // result
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_key_valid,
  output logic [alk_pkg::KEY_W-1:0]     out_key_code,
  output logic [alk_pkg::CNT_W-1:0]     out_digits_entered,
  output logic                          out_code_done,
  output logic                          out_code_correct,
  // configuration
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [alk_pkg::REG_W-1:0]     cfg_wdata
);
  import alk_pkg::*;

  // config registers
  logic [REG_W-1:0]    code_digits_r;
  logic [REG_W-1:0]    settle_samples_r;

  // input stage
  logic                in_full_r;
  logic [SAMPLE_W-1:0] in_sample_r;

  // result stage
  logic                out_valid_r;
  logic                out_key_valid_r;
  logic [KEY_W-1:0]    out_key_code_r;
  logic [CNT_W-1:0]    out_digits_entered_r;
  logic                out_code_done_r;
  logic                out_code_correct_r;

  logic                advance;
  logic                in_take;
  band_t               band;
  key_evt_t            key_evt;
  entry_t              entry;

  // The held sample moves on whenever the result slot is free or draining.
  assign advance  = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall = in_full_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Config writes: the one-bit index selects one of the two registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_digits_r    <= CODE_RESET;
      settle_samples_r <= SETTLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CODE_DIGITS:    code_digits_r    <= cfg_wdata;
        REG_SETTLE_SAMPLES: settle_samples_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_take) begin
      in_full_r <= 1'b1;
    end else if (advance) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_sample_r <= in_adc_sample;
    end
  end

  // Single-pass datapath: band decode -> press tracker -> entry collector
  alk_band u_band (
    .sample (in_sample_r),
    .band   (band)
  );

  alk_press u_press (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .sample         (in_sample_r),
    .band           (band),
    .settle_samples (settle_samples_r),
    .key_evt        (key_evt)
  );

  alk_entry #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_entry (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .key_evt     (key_evt),
    .code_digits (code_digits_r),
    .entry       (entry)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_key_valid_r      <= key_evt.valid;
      out_key_code_r       <= key_evt.valid ? key_evt.code : '0;  // zero when no key
      out_digits_entered_r <= entry.count;
      out_code_done_r      <= entry.done;
      out_code_correct_r   <= entry.correct;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_key_valid      = out_key_valid_r;
  assign out_key_code       = out_key_code_r;
  assign out_digits_entered = out_digits_entered_r;
  assign out_code_done      = out_code_done_r;
  assign out_code_correct   = out_code_correct_r;

  // Checks
  `include "analog_keypad_code_lock_assert.svh"

  `ALK_ASSERT_IMPL(a_done_has_key, clk, rst_n,
                   out_valid_r && out_code_done_r,
                   out_key_valid_r && out_digits_entered_r == '0,
                   "code_done without a key or with digits left")
  `ALK_ASSERT_IMPL(a_correct_needs_done, clk, rst_n,
                   out_valid_r && out_code_correct_r, out_code_done_r,
                   "code_correct without code_done")
  `ALK_ASSERT_IMPL(a_count_in_range, clk, rst_n, out_valid_r,
                   {1'b0, out_digits_entered_r} < (CNT_W + 1)'(CODE_LENGTH),
                   "digit count reached the code length")
  `ALK_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance, out_valid_r,
                   "advanced request did not reach the result register")

endmodule

@@ tb/tb_analog_keypad_code_lock.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad code lock testbench
// Sends ADC sample requests made up of mostly well-formed key presses,
// including code entries, letter keys, dropped presses and ladder noise.
// Each accepted sample goes through a cycle-free predictor of the band
// decode, debounce and code check. Every result request is checked field
// by field against the oldest prediction. Sender bursts, receiver stalls
// and one long receiver hold-off exercise back-pressure.
// ----------------------------------------------------------------------------
module tb_analog_keypad_code_lock;
  import alk_pkg::*;

  localparam int ENTRY_LEN      = 4;     // digits per code entry
  localparam int NO_BAND        = 16;    // sample sits on or outside the ladder
  localparam int RANDOM_ITEMS   = 800;
  localparam int PHASE_ITEMS    = 120;
  localparam int HOLDOFF_CYCLES = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request accepted

  // One result request as the block reports it
  typedef struct packed {
    logic             key_valid;
    logic [KEY_W-1:0] key_code;
    logic [CNT_W-1:0] digits;
    logic             done;
    logic             correct;
  } lock_result_t;

  logic                clk;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_adc_sample = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic                out_key_valid;
  logic [KEY_W-1:0]    out_key_code;
  logic [CNT_W-1:0]    out_digits_entered;
  logic                out_code_done;
  logic                out_code_correct;
  logic                cfg_we        = 1'b0;
  logic                cfg_index     = REG_CODE_DIGITS;
  logic [REG_W-1:0]    cfg_wdata     = '0;

  // Samples waiting to be offered, and results the lock should produce
  logic [SAMPLE_W-1:0] pending_samples [$];
  lock_result_t        expected_results [$];
  int                  samples_queued = 0;
  int                  mismatches     = 0;

  // Predictor copy of the lock: registers and press/entry state
  logic [REG_W-1:0]    code_reg   = CODE_RESET;
  logic [REG_W-1:0]    settle_reg = SETTLE_RESET;
  phase_t              lock_phase = PH_IDLE;
  logic [KEY_W-1:0]    held_band  = '0;
  logic [REG_W-1:0]    settle_cnt = '0;
  logic [KEY_W-1:0]    entry_buf [ENTRY_LEN];
  logic [CNT_W-1:0]    entry_cnt  = '0;

  // Sender burst shaping
  int burst_left = 0;
  int gap_left   = 0;

  // Receiver stall pattern and the one long hold-off
  int stall_mode    = 0;
  int stall_window  = 0;
  int holdoff_left  = 0;
  bit holdoff_armed = 1'b0;
  bit holdoff_done  = 1'b0;

  int           idle_cycles = 0;
  lock_result_t want;

  analog_keypad_code_lock #(
    .CODE_LENGTH(ENTRY_LEN)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_adc_sample      (in_adc_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_key_valid      (out_key_valid),
    .out_key_code       (out_key_code),
    .out_digits_entered (out_digits_entered),
    .out_code_done      (out_code_done),
    .out_code_correct   (out_code_correct),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Band lookup: strictly between two neighboring ladder edges
  function automatic int band_of_sample(logic [SAMPLE_W-1:0] s);
    for (int i = 0; i < KEY_BANDS; i++) begin
      if (s > BAND_EDGE[i] && s < BAND_EDGE[i+1]) return i;
    end
    return NO_BAND;
  endfunction

  function automatic int band_of_key(logic [KEY_W-1:0] key);
    for (int i = 0; i < KEY_BANDS; i++) begin
      if (BAND_KEY[i] == key) return i;
    end
    return 0;
  endfunction

  // Random reading inside band b, edges excluded
  function automatic logic [SAMPLE_W-1:0] band_sample(int b);
    return SAMPLE_W'($urandom_range(BAND_EDGE[b] + 1, BAND_EDGE[b+1] - 1));
  endfunction

  // Advance the lock by one accepted sample and queue the result it gives
  task automatic predict_keypad(logic [SAMPLE_W-1:0] s);
    int           band;
    lock_result_t r;
    band = band_of_sample(s);
    r    = '0;
    case (lock_phase)
      PH_SETTLE: begin
        // once the wait is used up, this reading confirms or drops the press
        if (settle_cnt >= settle_reg) begin
          lock_phase = (band != NO_BAND && band == held_band) ? PH_RELEASE : PH_IDLE;
        end else begin
          settle_cnt++;
        end
      end
      PH_RELEASE: begin
        if (s <= BAND_EDGE[0]) begin
          lock_phase  = PH_IDLE;
          r.key_valid = 1'b1;
          r.key_code  = BAND_KEY[held_band];
          // letters are reported but never collected
          if (r.key_code <= MAX_DIGIT) begin
            entry_buf[entry_cnt] = r.key_code;
            entry_cnt++;
            if (entry_cnt == ENTRY_LEN) begin
              r.done    = 1'b1;
              r.correct = 1'b1;
              // a code nibble above 9 can never match
              for (int i = 0; i < ENTRY_LEN; i++) begin
                if (entry_buf[i] != code_reg[4*(ENTRY_LEN-1-i) +: 4]) r.correct = 1'b0;
              end
              entry_cnt = '0;
            end
          end
        end
      end
      default: begin
        // idle, and the transient confirm code behaves the same
        lock_phase = PH_IDLE;
        if (band != NO_BAND) begin
          held_band  = KEY_W'(band);
          settle_cnt = '0;
          lock_phase = PH_SETTLE;
        end
      end
    endcase
    r.digits = entry_cnt;
    expected_results.push_back(r);
  endtask

  task automatic push_sample(logic [SAMPLE_W-1:0] s);
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  // One key press from the lock's idle state: first reading, settle filler,
  // confirming reading, a few held readings, then release. A broken press
  // ends on a confirming reading that misses the band.
  task automatic press_key(logic [KEY_W-1:0] key, bit broken);
    int b;
    b = band_of_key(key);
    push_sample(band_sample(b));
    repeat (settle_reg) push_sample(SAMPLE_W'($urandom_range(0, 1023)));
    if (!broken) begin
      push_sample(band_sample(b));
      repeat ($urandom_range(0, 3)) push_sample(SAMPLE_W'($urandom_range(119, 1023)));
      push_sample(SAMPLE_W'($urandom_range(0, 118)));
    end else begin
      case ($urandom_range(0, 2))
        0:       push_sample(band_sample((b + $urandom_range(1, 15)) % KEY_BANDS));
        1:       push_sample(SAMPLE_W'(BAND_EDGE[$urandom_range(1, 15)]));
        default: push_sample(SAMPLE_W'($urandom_range(0, 118)));
      endcase
    end
  endtask

  // Register write; only called while the lock is drained
  task automatic write_reg(logic idx, logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_CODE_DIGITS) code_reg = val;
    else settle_reg = val;
  endtask

  // Wait until every sample is taken and every result has come back,
  // then let the two-stage pipe settle. Sampled on the falling edge so the
  // driver's updates of the same rising edge are already visible.
  task automatic drain;
    while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Four random code digits
  function automatic logic [REG_W-1:0] random_digit_code();
    logic [REG_W-1:0] c;
    for (int i = 0; i < ENTRY_LEN; i++) c[4*i +: 4] = 4'($urandom_range(0, 9));
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps; a request stays up
  // with its sample unchanged until the lock takes it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_keypad(in_adc_sample);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_adc_sample <= pending_samples.pop_front();
          in_valid      <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // new burst; a quarter of them follow on with no gap at all
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: checks each accepted result, and stalls on a pattern that
  // is drawn anew for each stall window (none, light, heavy, alternating).
  // The first hold-off request from the stimulus turns into one long stall
  // so the pipe fills and in_stall rises.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual key %0d valid %0b",
                   $time, out_key_code, out_key_valid);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("key_valid",      want.key_valid, out_key_valid);
          check_field("key_code",       want.key_code,  out_key_code);
          check_field("digits_entered", want.digits,    out_digits_entered);
          check_field("code_done",      want.done,      out_code_done);
          check_field("code_correct",   want.correct,   out_code_correct);
        end
      end

      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else if (holdoff_armed && !holdoff_done) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES - 1;
        out_stall    <= 1'b1;
      end else begin
        if (stall_window == 0) begin
          stall_mode   = $urandom_range(0, 3);
          stall_window = 64;
        end
        stall_window--;
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 99) < 30);
          2:       out_stall <= ($urandom_range(0, 99) < 75);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Watchdog: too long without any request moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int code_seq [12];
    int odd_seq  [6];
    int phase_no;
    int phase_end;
    int pad;
    int special_band;
    bit exact;
    logic [KEY_W-1:0] nib;

    // settle 0 presses: 1 5 9 7 at the band edges, released by low readings
    code_seq = '{119, 169, 0,  371, 421, 118,  630, 685, 60,  221, 271, 5};
    // reading on a threshold (no band), press dropped by the wrong band,
    // then letter C held at full scale
    odd_seq  = '{897, 898, 119,  1023, 1023, 3};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part ----
    // reset setup: full scale starts a press, the wait of 50 keeps it settling
    push_sample(10'd1023);
    push_sample(10'd0);
    push_sample(10'd118);
    drain();
    // wait lowered below the count reached: the next reading confirms
    write_reg(REG_SETTLE_SAMPLES, 16'd0);
    push_sample(10'd1023);
    push_sample(10'd119);
    push_sample(10'd118);
    drain();
    write_reg(REG_CODE_DIGITS, 16'h1597);
    foreach (code_seq[i]) push_sample(SAMPLE_W'(code_seq[i]));
    foreach (odd_seq[i]) push_sample(SAMPLE_W'(odd_seq[i]));
    drain();

    // ---- random part, one register setting per phase ----
    holdoff_armed = 1'b1;
    samples_queued = 0;
    for (phase_no = 0; samples_queued < RANDOM_ITEMS; phase_no++) begin
      case (phase_no)
        0: begin
          write_reg(REG_SETTLE_SAMPLES, 16'd1);
          write_reg(REG_CODE_DIGITS, 16'h1597);
        end
        1: begin
          write_reg(REG_SETTLE_SAMPLES, 16'd0);
          write_reg(REG_CODE_DIGITS, 16'h0000);
        end
        2: begin
          // every nibble above 9: no entry can ever be correct
          write_reg(REG_SETTLE_SAMPLES, 16'd2);
          write_reg(REG_CODE_DIGITS, 16'hFFFF);
        end
        3: begin
          write_reg(REG_SETTLE_SAMPLES, 16'd3);
          write_reg(REG_CODE_DIGITS, 16'h9999);
        end
        4: begin
          write_reg(REG_SETTLE_SAMPLES, 16'd2);
          write_reg(REG_CODE_DIGITS, random_digit_code());
        end
        default: begin
          write_reg(REG_SETTLE_SAMPLES, 16'($urandom_range(0, 4)));
          write_reg(REG_CODE_DIGITS,
                    ($urandom_range(0, 2) == 0) ? 16'($urandom) : random_digit_code());
        end
      endcase

      // finish any entry left half done so later entries line up with the code
      pad = (ENTRY_LEN - entry_cnt) % ENTRY_LEN;
      repeat (pad) press_key(4'($urandom_range(0, 9)), 1'b0);

      if (phase_no == 4) begin
        // longest wait: a letter press settles for a while, then the wait
        // is lowered under the count and the next reading confirms it
        drain();
        write_reg(REG_SETTLE_SAMPLES, 16'hFFFF);
        special_band = band_of_key(4'($urandom_range(10, 15)));
        push_sample(band_sample(special_band));
        repeat (30) push_sample(SAMPLE_W'($urandom_range(0, 1023)));
        drain();
        write_reg(REG_SETTLE_SAMPLES, 16'd2);
        push_sample(band_sample(special_band));
        push_sample(SAMPLE_W'($urandom_range(0, 118)));
      end

      // entries of four digits, either the code or random digits, with
      // letters and dropped presses mixed in
      phase_end = samples_queued + PHASE_ITEMS;
      while (samples_queued < phase_end) begin
        exact = $urandom_range(0, 1);
        for (int d = 0; d < ENTRY_LEN; d++) begin
          if ($urandom_range(0, 4) == 0) press_key(4'($urandom_range(10, 15)), 1'b0);
          if ($urandom_range(0, 6) == 0) press_key(4'($urandom_range(0, 15)), 1'b1);
          nib = code_reg[4*(ENTRY_LEN-1-d) +: 4];
          press_key((exact && nib <= MAX_DIGIT) ? nib : 4'($urandom_range(0, 9)), 1'b0);
        end
      end

      // ladder noise, then enough low readings to bring the lock back to idle
      repeat (2) begin
        repeat ($urandom_range(1, 6)) push_sample(SAMPLE_W'($urandom_range(0, 1023)));
      end
      repeat (settle_reg + 2) push_sample(SAMPLE_W'($urandom_range(0, 118)));
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
